### rtl/bdsd_pkg.sv
package bdsd_pkg;

    localparam int BLOCK_LEN_DEF = 64;
    localparam int MAP_W         = 64;
    localparam int WORD_W        = 32;
    localparam int QUEUE_DEPTH   = 2;

    // Input mode codes
    localparam logic [1:0] MODE_DELTA  = 2'd0;
    localparam logic [1:0] MODE_SPARSE = 2'd1;
    localparam logic [1:0] MODE_DATA   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Queued command codes
    localparam logic [1:0] OP_DELTA  = 2'd0;
    localparam logic [1:0] OP_SPARSE = 2'd1;
    localparam logic [1:0] OP_DATA   = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [WORD_W-1:0] operand;   // base for sparse headers, value for data
        logic [MAP_W-1:0]  map;
    } t_cmd;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            sat_add = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            sat_add = s[WORD_W-1:0];
        end
    endfunction

endpackage

### rtl/bdsd_front.sv
module bdsd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_mode,
    input  logic [bdsd_pkg::WORD_W-1:0]  i_base,
    input  logic [bdsd_pkg::WORD_W-1:0]  i_bitmap_high,
    input  logic [bdsd_pkg::WORD_W-1:0]  i_bitmap_low,
    input  logic [bdsd_pkg::WORD_W-1:0]  i_value,
    output logic                         o_push_valid,
    input  logic                         i_push_ready,
    output bdsd_pkg::t_cmd               o_push_cmd
);
    import bdsd_pkg::*;

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic in_fire;

    assign o_ready = !r_valid || i_push_ready;
    assign in_fire = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid && !i_push_ready;
        n_cmd   = r_cmd;
        if (in_fire) begin
            case (i_mode)
                MODE_DELTA: begin
                    n_valid       = 1'b1;
                    n_cmd.op      = OP_DELTA;
                    n_cmd.operand = '0;
                    n_cmd.map     = '0;
                end
                MODE_SPARSE: begin
                    n_valid       = 1'b1;
                    n_cmd.op      = OP_SPARSE;
                    n_cmd.operand = i_base;
                    n_cmd.map     = {i_bitmap_high, i_bitmap_low};
                end
                MODE_DATA: begin
                    n_valid       = 1'b1;
                    n_cmd.op      = OP_DATA;
                    n_cmd.operand = i_value;
                    n_cmd.map     = '0;
                end
                default: begin
                    // drop unused mode
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

endmodule

### rtl/bdsd_fifo.sv
module bdsd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  bdsd_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output bdsd_pkg::t_cmd o_pop_cmd
);
    import bdsd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_fire, pop_fire;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push_fire    = i_push_valid && o_push_ready;
    assign pop_fire     = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_fire) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_fire) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            n_count = r_count + 1'b1;
        end else if (pop_fire && !push_fire) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

### rtl/bdsd_back.sv
module bdsd_back #(
    parameter int BLOCK_LEN = bdsd_pkg::BLOCK_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_pop_valid,
    output logic                         o_pop_ready,
    input  bdsd_pkg::t_cmd               i_pop_cmd,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bdsd_pkg::WORD_W-1:0]  o_sample,
    output logic                         o_last
);
    import bdsd_pkg::*;

    localparam int POS_W = $clog2(BLOCK_LEN);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              r_state, n_state;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_kind, n_kind;
    logic              r_in_block, n_in_block;
    logic [WORD_W-1:0] r_base, n_base;
    logic [MAP_W-1:0]  r_map, n_map;
    logic [WORD_W-1:0] r_sum, n_sum;
    logic              r_ov, n_ov;
    logic [WORD_W-1:0] r_sample, n_sample;
    logic              r_last, n_last;

    logic              out_free, pop_fire, emit, at_end;
    logic [WORD_W-1:0] emit_val, delta_val;

    assign out_free    = !r_ov || i_ready;
    assign o_pop_ready = (r_state == ST_IDLE) && out_free;
    assign pop_fire    = i_pop_valid && o_pop_ready;
    assign at_end      = (r_pos == POS_W'(BLOCK_LEN - 1));
    assign delta_val   = (r_pos == '0) ? i_pop_cmd.operand : sat_add(r_sum, i_pop_cmd.operand);

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_kind     = r_kind;
        n_in_block = r_in_block;
        n_base     = r_base;
        n_map      = r_map;
        n_sum      = r_sum;
        n_ov       = r_ov && !i_ready;
        n_sample   = r_sample;
        n_last     = r_last;
        emit       = 1'b0;
        emit_val   = r_base;

        if (pop_fire) begin
            case (i_pop_cmd.op)
                OP_DELTA: begin
                    n_kind     = 1'b0;
                    n_in_block = 1'b1;
                    n_pos      = '0;
                    n_sum      = '0;
                end
                OP_SPARSE: begin
                    n_kind     = 1'b1;
                    n_in_block = 1'b1;
                    n_pos      = '0;
                    n_base     = i_pop_cmd.operand;
                    n_map      = i_pop_cmd.map;
                    n_state    = ST_RUN;
                end
                OP_DATA: begin
                    if (r_in_block) begin
                        emit = 1'b1;
                        if (!r_kind) begin
                            n_sum    = delta_val;
                            emit_val = delta_val;
                        end else begin
                            emit_val = sat_add(i_pop_cmd.operand, r_base);
                            n_state  = ST_RUN;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (r_state == ST_RUN && out_free) begin
            // emit base while the current position is cleared
            if (r_in_block && !r_map[MAP_W-1]) begin
                emit = 1'b1;
            end else begin
                n_state = ST_IDLE;
            end
        end

        if (emit) begin
            n_ov     = 1'b1;
            n_sample = emit_val;
            n_last   = at_end;
            n_map    = {r_map[MAP_W-2:0], 1'b0};
            if (at_end) begin
                n_pos      = '0;
                n_in_block = 1'b0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pos      <= '0;
            r_kind     <= 1'b0;
            r_in_block <= 1'b0;
            r_base     <= '0;
            r_map      <= '0;
            r_sum      <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_kind     <= n_kind;
            r_in_block <= n_in_block;
            r_base     <= n_base;
            r_map      <= n_map;
            r_sum      <= n_sum;
            r_ov       <= n_ov;
        end
        r_sample <= n_sample;
        r_last   <= n_last;
    end

    assign o_valid  = r_ov;
    assign o_sample = r_sample;
    assign o_last   = r_last;

    a_run_sparse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> r_kind)
        else $error("cleared-run sequencing outside a sparse block");

    a_pos_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> r_in_block)
        else $error("nonzero position with no open block");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (!r_in_block && r_pos == '0))
        else $error("block still open after its last beat");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> ($stable(r_sample) && $stable(r_pos)))
        else $error("state advanced while output beat stalled");

endmodule

### rtl/block_delta_sparse_decoder.sv
// An accepted beat reaches the output through the input register, the queue and the output register;
// when a sparse header opens the block, a sequencer step also lies between the queue and the output register.
// Header and delta data beats do not hold the back sequencer; a sparse data beat or sparse header
// holds it, and no new beat is taken, until it has emitted the run of cleared positions that follows.
// A sparse header whose first position is set still passes through the run state in the sequencer.
// Reset (synchronous, active low) clears the input and output valid flags, the queue and the block state.
module block_delta_sparse_decoder #(
    parameter int BLOCK_LEN = bdsd_pkg::BLOCK_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_mode,
    input  logic [bdsd_pkg::WORD_W-1:0]  i_base,
    input  logic [bdsd_pkg::WORD_W-1:0]  i_bitmap_high,
    input  logic [bdsd_pkg::WORD_W-1:0]  i_bitmap_low,
    input  logic [bdsd_pkg::WORD_W-1:0]  i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bdsd_pkg::WORD_W-1:0]  o_sample,
    output logic                         o_last
);
    import bdsd_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    t_cmd push_cmd, pop_cmd;

    bdsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_base        (i_base),
        .i_bitmap_high (i_bitmap_high),
        .i_bitmap_low  (i_bitmap_low),
        .i_value       (i_value),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_cmd    (push_cmd)
    );

    bdsd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    bdsd_back #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_cmd   (pop_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample    (o_sample),
        .o_last      (o_last)
    );

endmodule
